// ----- rtl/segmented_running_mode_assert.svh -----
// assertion macros for the segmented running mode block
// used by the checker module only
`ifndef SEGMENTED_RUNNING_MODE_ASSERT_SVH
`define SEGMENTED_RUNNING_MODE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SRM_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define SRM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- rtl/srm_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the segmented running mode block
// no dependencies
package srm_pkg;
  localparam int TableDepth = 128;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam logic [15:0] Sat16 = 16'hFFFF;

  localparam logic [1:0] StOverflow = 2'b01;
  localparam logic [1:0] StBadMonth = 2'b10;

  typedef struct packed {
    logic [23:0] store_id;
    logic [3:0]  month_num;
    logic signed [23:0] price_cents;
    logic        end_of_stream;
  } srm_in_t;

  typedef struct packed {
    logic signed [23:0] modal_price;
    logic [15:0] modal_count;
    logic [15:0] segment_length;
    logic [1:0]  status;
    logic        last_result;
  } srm_out_t;

  function automatic logic [2:0] quarter_of(input logic [3:0] m);
    logic [2:0] q;
    case (m)
      4'd1, 4'd2, 4'd3:    q = 3'd1;
      4'd4, 4'd5, 4'd6:    q = 3'd2;
      4'd7, 4'd8, 4'd9:    q = 3'd3;
      4'd10, 4'd11, 4'd12: q = 3'd4;
      default:             q = 3'd0;
    endcase
    return q;
  endfunction
endpackage

// ----- rtl/srm_in_if.sv -----
`timescale 1ns / 1ps
// valid/ready channels for input and result words
// depends on srm_pkg
interface srm_in_if import srm_pkg::*; ();
  logic    valid;
  logic    ready;
  srm_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srm_out_if import srm_pkg::*; ();
  logic     valid;
  logic     ready;
  srm_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/segmented_running_mode.sv -----
`timescale 1ns / 1ps
// Per-segment modal price. The time one word takes grows with N, the number of
// table entries in use (up to 128), set by the linear search through the
// value/count memory (no search when the price is not positive); a word that
// closes a segment adds a mode scan over that segment's table, so the worst
// case is a full-table search followed by the end-of-stream scan. A word is
// taken only when the two-word result queue has room for both results it
// may cause.
// depends on srm_pkg, srm_in_if, srm_seq, srm_out_buf
module segmented_running_mode import srm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  srm_in_if.sink    in,
  srm_out_if.source out
);
  logic     tie_q;
  logic     space2, push;
  srm_out_t word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tie_q <= 1'b1;
    else if (cfg_we_i) tie_q <= cfg_wdata_i;
  end

  srm_seq u_seq (
    .clk_i(clk_i), .rst_ni(rst_ni), .tie_lowest_i(tie_q), .in(in),
    .space2_i(space2), .push_o(push), .word_o(word)
  );

  srm_out_buf u_buf (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .word_i(word),
    .space2_o(space2), .out(out)
  );
endmodule

// ----- rtl/srm_table_ram.sv -----
`timescale 1ns / 1ps
// value/count table memory, one write and one registered read port
// depends on srm_pkg
module srm_table_ram import srm_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [39:0]     wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [39:0]     rdata_o
);
  logic [39:0] mem_q [TableDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/srm_out_buf.sv -----
`timescale 1ns / 1ps
// two-entry result queue that decouples the sequencer from the sink
// depends on srm_pkg
module srm_out_buf import srm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  srm_out_t  word_i,
  output logic      space2_o,
  srm_out_if.source out
);
  srm_out_t   buf_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop = out.valid && out.ready;
  assign out.valid = (cnt_q != 2'd0);
  assign out.data = buf_q[rd_q];
  assign space2_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_q] <= word_i;
  end
endmodule

// ----- rtl/srm_seq.sv -----
`timescale 1ns / 1ps
// sequencer: search/update of the table and mode scan at segment end
// depends on srm_pkg, srm_table_ram
module srm_seq import srm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     tie_lowest_i,
  srm_in_if.sink   in,
  input  logic     space2_i,
  output logic     push_o,
  output srm_out_t word_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_SCAN1, S_SCAN2, S_COUNT, S_SCANB, S_DONE
  } state_e;

  state_e       state_q;
  srm_in_t      item_q;
  logic [2:0]   itq_q;
  logic [CntW-1:0] used_q, ptr_q;
  logic [23:0]  pstore_q;
  logic [2:0]   pq_q;
  logic [15:0]  segcnt_q;
  logic [1:0]   segst_q;
  logic         open_q;
  logic         rvld_q;
  logic [IdxW-1:0] ridx_q;
  logic [23:0]  bprice_q;
  logic [15:0]  bcnt_q;
  logic         bfirst_q;

  logic          we;
  logic [IdxW-1:0] waddr, raddr;
  logic [39:0]   wdata, rdata;
  logic [23:0]   rv;
  logic [15:0]   rc;
  logic          positive;

  assign rv = rdata[39:16];
  assign rc = rdata[15:0];
  assign positive = !item_q.price_cents[23] && (item_q.price_cents != '0);
  assign in.ready = (state_q == S_IDLE) && space2_i;

  srm_table_ram u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // read address runs one ahead of the registered data; a walk starts at entry 0
  assign raddr = (state_q == S_SCAN1 || state_q == S_SCANB || state_q == S_SRCH) ?
                 ptr_q[IdxW-1:0] : '0;

  always_comb begin
    we = 1'b0;
    waddr = ridx_q;
    wdata = {rv, (rc == Sat16) ? rc : rc + 16'd1};
    if (state_q == S_SRCH && rvld_q && rv == item_q.price_cents) begin
      we = 1'b1;
    end else if (state_q == S_SRCH && ptr_q == used_q && !rvld_q) begin
      we = (used_q < CntW'(TableDepth));
      waddr = used_q[IdxW-1:0];
      wdata = {item_q.price_cents, 16'd1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= '0;
      pstore_q <= '0;
      pq_q <= '0;
      segcnt_q <= '0;
      segst_q <= '0;
      open_q <= 1'b0;
      rvld_q <= 1'b0;
      push_o <= 1'b0;
      ptr_q <= '0;
    end else begin
      push_o <= 1'b0;
      rvld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in.valid && in.ready) begin
            item_q <= in.data;
            itq_q <= quarter_of(in.data.month_num);
            ptr_q <= '0;
            bfirst_q <= 1'b1;
            if (open_q && (in.data.store_id != pstore_q ||
                quarter_of(in.data.month_num) != pq_q)) begin
              state_q <= S_SCAN1;
              if (used_q != '0) begin
                ptr_q <= CntW'(1);
                rvld_q <= 1'b1;
              end
              ridx_q <= '0;
            end else begin
              state_q <= S_COUNT;
            end
          end
        end
        S_SCAN1, S_SCANB: begin
          // walk the table, keep best count with tie rule
          if (rvld_q) begin
            if (bfirst_q || rc > bcnt_q ||
                (rc == bcnt_q && (tie_lowest_i ? rv < bprice_q : rv > bprice_q))) begin
              bprice_q <= rv;
              bcnt_q <= rc;
            end
            bfirst_q <= 1'b0;
          end
          if (ptr_q < used_q) begin
            ridx_q <= ptr_q[IdxW-1:0];
            ptr_q <= ptr_q + CntW'(1);
            rvld_q <= 1'b1;
          end else if (!rvld_q) begin
            state_q <= S_SCAN2;
          end
        end
        S_SCAN2: begin
          push_o <= 1'b1;
          word_o.modal_price <= bfirst_q ? '0 : bprice_q;
          word_o.modal_count <= bfirst_q ? '0 : bcnt_q;
          word_o.segment_length <= segcnt_q;
          word_o.status <= segst_q;
          // a closed-by-change word is last unless end of stream follows
          word_o.last_result <= !open_q || !item_q.end_of_stream;
          if (open_q) begin
            open_q <= 1'b0;
            state_q <= S_COUNT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_COUNT: begin
          if (!open_q) begin
            used_q <= '0;
            segcnt_q <= 16'd1;
            segst_q <= (itq_q == 3'd0) ? StBadMonth : 2'b00;
            pstore_q <= item_q.store_id;
            pq_q <= itq_q;
            open_q <= 1'b1;
          end else begin
            if (segcnt_q != Sat16) segcnt_q <= segcnt_q + 16'd1;
            if (itq_q == 3'd0) segst_q <= segst_q | StBadMonth;
          end
          ptr_q <= '0;
          if (positive) begin
            state_q <= S_SRCH;
            if (open_q && used_q != '0) begin
              ptr_q <= CntW'(1);
              rvld_q <= 1'b1;
            end
            ridx_q <= '0;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_SRCH: begin
          if (rvld_q && rv == item_q.price_cents) begin
            state_q <= S_DONE;
          end else if (ptr_q < used_q) begin
            ridx_q <= ptr_q[IdxW-1:0];
            ptr_q <= ptr_q + CntW'(1);
            rvld_q <= 1'b1;
          end else if (!rvld_q) begin
            if (used_q < CntW'(TableDepth)) used_q <= used_q + CntW'(1);
            else segst_q <= segst_q | StOverflow;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (item_q.end_of_stream) begin
            state_q <= S_SCANB;
            bfirst_q <= 1'b1;
            ptr_q <= '0;
            open_q <= 1'b0;
            if (used_q != '0) begin
              ptr_q <= CntW'(1);
              rvld_q <= 1'b1;
            end
            ridx_q <= '0;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/srm_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the segmented running mode block
// depends on srm_pkg and the assertion macro header
`include "segmented_running_mode_assert.svh"
module srm_checker import srm_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input srm_out_t out_data
);
  `SRM_ASSERT_IMPL(a_cnt_le_len, clk_i, rst_ni, out_valid, out_data.modal_count <= out_data.segment_length)
  `SRM_ASSERT_IMPL(a_len_nz, clk_i, rst_ni, out_valid, out_data.segment_length != 16'd0)
  `SRM_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, out_valid && out_data.modal_count == 16'd0, out_data.modal_price == '0)
  `SRM_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid && in_ready, !in_ready)
endmodule

bind segmented_running_mode srm_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .out_data(out.data)
);

// ----- bench/segmented_running_mode_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for segmented_running_mode: directed, overflow, random segments
// depends on srm_pkg, srm_in_if/srm_out_if and the block itself
module segmented_running_mode_test;
  import srm_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DirRows = 25;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  srm_in_if  in_ch ();
  srm_out_if out_ch ();

  segmented_running_mode dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in(in_ch.sink), .out(out_ch.source)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [23:0] price_tab [TableDepth];
  logic [15:0] count_tab [TableDepth];
  int unsigned used_n;
  logic [23:0] seg_store;
  logic [2:0]  seg_qtr;
  logic [15:0] seg_len;
  logic [1:0]  seg_flags;
  logic        seg_live;
  logic        tie_low;

  srm_out_t modes_due[$];
  int errors = 0;
  int idle_cycles = 0;
  logic timed_out = 1'b0;
  logic done_flag = 1'b0;

  function automatic logic [2:0] month_quarter(logic [3:0] m);
    if (m >= 1 && m <= 3) return 3'd1;
    if (m >= 4 && m <= 6) return 3'd2;
    if (m >= 7 && m <= 9) return 3'd3;
    if (m >= 10 && m <= 12) return 3'd4;
    return 3'd0;
  endfunction

  function automatic srm_out_t segment_mode();
    srm_out_t r;
    logic [23:0] bp;
    logic [15:0] bc;
    bp = '0;
    bc = '0;
    for (int j = 0; j < used_n; j++) begin
      if (j == 0 || count_tab[j] > bc) begin
        bc = count_tab[j];
        bp = price_tab[j];
      end else if (count_tab[j] == bc) begin
        if (tie_low ? (price_tab[j] < bp) : (price_tab[j] > bp)) bp = price_tab[j];
      end
    end
    r.modal_price = bp;
    r.modal_count = bc;
    r.segment_length = seg_len;
    r.status = seg_flags;
    r.last_result = 1'b0;
    return r;
  endfunction

  task automatic predict_word(srm_in_t w);
    logic [2:0] q;
    srm_out_t r;
    int n;
    bit hit;
    q = month_quarter(w.month_num);
    n = 0;
    if (seg_live && (w.store_id != seg_store || q != seg_qtr)) begin
      modes_due.push_back(segment_mode());
      n++;
      seg_live = 0;
    end
    if (!seg_live) begin
      used_n = 0;
      seg_len = 0;
      seg_flags = 0;
      seg_store = w.store_id;
      seg_qtr = q;
      seg_live = 1;
    end
    if (q == 0) seg_flags |= StBadMonth;
    if (seg_len != Sat16) seg_len++;
    if (w.price_cents > 0) begin
      hit = 0;
      for (int j = 0; j < used_n && !hit; j++)
        if (price_tab[j] == w.price_cents) begin
          hit = 1;
          if (count_tab[j] != Sat16) count_tab[j]++;
        end
      if (!hit) begin
        if (used_n < TableDepth) begin
          price_tab[used_n] = w.price_cents;
          count_tab[used_n] = 1;
          used_n++;
        end else seg_flags |= StOverflow;
      end
    end
    if (w.end_of_stream) begin
      modes_due.push_back(segment_mode());
      n++;
      seg_live = 0;
    end
    if (n > 0) begin
      r = modes_due.pop_back();
      r.last_result = 1'b1;
      modes_due.push_back(r);
    end
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 4) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // result side: random stalls, compare against the oldest expectation
  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    srm_out_t e;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (modes_due.size() == 0) begin
          $error("unexpected result word %h", out_ch.data);
          errors++;
        end else begin
          e = modes_due.pop_front();
          if (out_ch.data.modal_price !== e.modal_price) begin
            $error("modal_price exp %0d got %0d", e.modal_price, out_ch.data.modal_price);
            errors++;
          end
          if (out_ch.data.modal_count !== e.modal_count) begin
            $error("modal_count exp %0d got %0d", e.modal_count, out_ch.data.modal_count);
            errors++;
          end
          if (out_ch.data.segment_length !== e.segment_length) begin
            $error("segment_length exp %0d got %0d", e.segment_length,
                   out_ch.data.segment_length);
            errors++;
          end
          if (out_ch.data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_ch.data.status);
            errors++;
          end
          if (out_ch.data.last_result !== e.last_result) begin
            $error("last_result exp %0d got %0d", e.last_result, out_ch.data.last_result);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left <= gap_len();
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      timed_out <= 1'b1;
    end
  end

  // valid stays high after an accept when the next word follows with no gap
  task automatic send_word(srm_in_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_word(w);
  endtask

  task automatic write_tie(logic v);
    in_ch.valid <= 1'b0;
    while (modes_due.size() != 0) @(posedge clk_i);
    repeat (450) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tie_low = v;
  endtask

  function automatic srm_in_t mk(logic [23:0] s, logic [3:0] m, logic [23:0] p, logic e);
    srm_in_t w;
    w.store_id = s;
    w.month_num = m;
    w.price_cents = p;
    w.end_of_stream = e;
    return w;
  endfunction

  function automatic srm_out_t mk_exp(logic [23:0] p, logic [15:0] c, logic [15:0] l,
                                      logic [1:0] s, logic last);
    srm_out_t r;
    r.modal_price = p;
    r.modal_count = c;
    r.segment_length = l;
    r.status = s;
    r.last_result = last;
    return r;
  endfunction

  // directed table: extremes, invalid months, quarter and store changes, end of stream
  srm_in_t  directed [DirRows];
  logic     has_exp [DirRows];
  srm_out_t dir_exp [DirRows];
  initial begin
    foreach (has_exp[i]) has_exp[i] = 1'b0;
    directed[0]  = mk(24'h0, 4'd1, 24'd0, 1'b1);
    directed[1]  = mk(24'h0, 4'd1, 24'd0, 1'b0);
    directed[2]  = mk(24'h0, 4'd3, 24'h7FFFFF, 1'b0);
    directed[3]  = mk(24'h0, 4'd2, 24'h800000, 1'b0);
    directed[4]  = mk(24'h0, 4'd4, 24'd1, 1'b0);
    directed[5]  = mk(24'h0, 4'd6, 24'd1, 1'b1);
    directed[6]  = mk(24'hFFFFFF, 4'd12, 24'hFFFFFF, 1'b1);
    directed[7]  = mk(24'hFFFFFF, 4'd0, 24'd5, 1'b0);
    directed[8]  = mk(24'hFFFFFF, 4'd15, 24'd7, 1'b0);
    directed[9]  = mk(24'hFFFFFF, 4'd13, 24'd5, 1'b0);
    directed[10] = mk(24'h123456, 4'd7, 24'd9, 1'b0);
    directed[11] = mk(24'h123456, 4'd9, 24'd3, 1'b0);
    directed[12] = mk(24'h123456, 4'd10, 24'd3, 1'b1);
    directed[13] = mk(24'h5, 4'd11, 24'd100, 1'b0);
    directed[14] = mk(24'h5, 4'd11, 24'd200, 1'b0);
    directed[15] = mk(24'h6, 4'd11, 24'd300, 1'b1);
    directed[16] = mk(24'h6, 4'd5, 24'd0, 1'b1);
    directed[17] = mk(24'h6, 4'd8, 24'd2, 1'b0);
    directed[18] = mk(24'h6, 4'd8, 24'd4, 1'b0);
    directed[19] = mk(24'h6, 4'd8, 24'h555555, 1'b1);
    directed[20] = mk(24'hAAAAAA, 4'd14, 24'h2AAAAA, 1'b0);
    directed[21] = mk(24'h555555, 4'd1, 24'h7FFFFF, 1'b0);
    directed[22] = mk(24'h555555, 4'd2, 24'h7FFFFF, 1'b1);
    directed[23] = mk(24'h555555, 4'd3, 24'd8, 1'b0);
    directed[24] = mk(24'h1, 4'd1, 24'd8, 1'b1);
    // empty segment closed by end of stream
    has_exp[0] = 1'b1;
    dir_exp[0] = mk_exp(24'd0, 16'd0, 16'd1, 2'b00, 1'b1);
    // negative price alone in its segment
    has_exp[6] = 1'b1;
    dir_exp[6] = mk_exp(24'd0, 16'd0, 16'd1, 2'b00, 1'b1);
    // invalid months share quarter 0, closed by a store change
    has_exp[10] = 1'b1;
    dir_exp[10] = mk_exp(24'd5, 16'd2, 16'd3, StBadMonth, 1'b1);
  end

  task automatic run_directed();
    for (int i = 0; i < DirRows; i++) begin
      send_word(directed[i]);
      if (has_exp[i]) modes_due[modes_due.size() - 1] = dir_exp[i];
    end
  endtask

  initial begin
    srm_in_t w;
    int items, run, vals;
    logic [23:0] st;
    logic [3:0] mo;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    tie_low = 1'b1;
    used_n = 0;
    seg_store = 0;
    seg_qtr = 0;
    seg_len = 0;
    seg_flags = 0;
    seg_live = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    write_tie(1'b0);
    run_directed();

    // table overflow: 130 distinct prices in one segment
    for (int i = 0; i < 130; i++) send_word(mk(24'h77, 4'd2, 24'(i + 1), i == 129));
    write_tie(1'b1);

    // random segments: few distinct prices so ties and repeats are common
    items = 0;
    while (items < 670) begin
      if ($urandom_range(0, 9) == 0) write_tie(1'($urandom_range(0, 1)));
      st = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3));
      mo = 4'($urandom_range(0, 15));
      run = $urandom_range(1, 12);
      vals = $urandom_range(1, 6);
      for (int k = 0; k < run; k++) begin
        w.store_id = st;
        w.month_num = ($urandom_range(0, 4) == 0) ? 4'($urandom) : mo;
        case ($urandom_range(0, 9))
          0: w.price_cents = 24'($urandom);
          1: w.price_cents = 24'h800000 | 24'($urandom);
          2: w.price_cents = 24'd0;
          default: w.price_cents = 24'($urandom_range(1, vals));
        endcase
        w.end_of_stream = ($urandom_range(0, 29) == 0);
        send_word(w);
        items++;
      end
    end
    send_word(mk(24'h0, 4'd1, 24'd1, 1'b1));
    in_ch.valid <= 1'b0;
    done_flag = 1'b1;
  end

  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (timed_out) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // end of run once the final word and its results are through
  initial begin
    wait (rst_ni);
    wait (done_flag);
    while (modes_due.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    if (errors == 0 && modes_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/srm_pkg.sv
rtl/srm_in_if.sv
rtl/srm_table_ram.sv
rtl/srm_out_buf.sv
rtl/srm_seq.sv
rtl/segmented_running_mode.sv
rtl/srm_checker.sv
bench/segmented_running_mode_test.sv
